// File: sv/chmac_pkg.sv
// Package for the keyed CubeHash MAC: payload types, sequencer states, round function.
package chmac_pkg;

    localparam int ROUNDS_PER_PERMUTE = 16;
    localparam int BLOCK_BYTES        = 32;
    localparam int FINAL_PERMUTES     = 2;

    localparam int PERM_HALVES  = 2 * ROUNDS_PER_PERMUTE;
    localparam int FINAL_HALVES = 2 * ROUNDS_PER_PERMUTE * FINAL_PERMUTES;
    localparam int CNT_W        = $clog2(FINAL_HALVES);

    localparam int KEY_PARTS = 8;
    localparam int CFG_IDX_W = 4;

    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [31:0] IV_WORD_0 = 32'd16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_item;
    } t_in_item;

    typedef struct packed {
        logic [63:0] tag_high;
        logic [63:0] tag_low;
    } t_out_item;

    typedef logic [31:0][31:0] t_cube;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PERM,
        S_KEY_A,
        S_KEY_B,
        S_ABSORB,
        S_PAD,
        S_TAIL,
        S_OUT
    } t_state;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
        rotl32 = (v << r) | (v >> (32 - r));
    endfunction

    // One half round; second_half picks rotate 11 with swaps 4/1, else rotate 7 with 8/2
    function automatic t_cube half_round(input t_cube w, input logic second_half);
        t_cube            res;
        logic [15:0][31:0] b;
        int               rot;
        int               sw_lo;
        int               sw_hi;
        rot   = second_half ? 11 : 7;
        sw_lo = second_half ? 4 : 8;
        sw_hi = second_half ? 1 : 2;
        for (int i = 0; i < 16; i++) begin
            b[i] = w[i + 16] + w[i];
        end
        for (int i = 0; i < 16; i++) begin
            res[i]      = rotl32(w[i ^ sw_lo], rot) ^ b[i];
            res[i + 16] = b[i ^ sw_hi];
        end
        half_round = res;
    endfunction

endpackage

// File: sv/cubehash_keyed_mac.sv
// Keyed CubeHash MAC top level: key registers, state cube, round sequencer, tag output.
// Each permutation runs one half round a cycle on the shared half-round unit.
// A byte word is taken, absorbed and pad-checked, plus a permutation after each 32nd byte;
// a message start adds the key rebuild, and the last word adds the pad permutation and the
// finalization before the tag. Throughput is set by the single half-round unit; one word at a time.
// Reset (synchronous, active low) clears the key to zero and marks the next word as a
// message start; the cube itself is rebuilt at that start and needs no reset.
module cubehash_keyed_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  chmac_pkg::t_in_item             i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output chmac_pkg::t_out_item            o_out_data,
    input  logic                            i_cfg_we,
    input  logic [chmac_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                     i_cfg_data
);
    import chmac_pkg::*;

    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [4:0]         r_pos, n_pos;
    logic               r_fresh, n_fresh;
    t_in_item           r_item, n_item;
    t_cube              r_cube, n_cube;
    logic [63:0]        r_key [KEY_PARTS];
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               in_accept;
    logic [2:0]         byte_word;
    logic [31:0]        byte_mask;
    t_cube              round_out;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Shared half-round unit; counter parity picks the half
    assign round_out = half_round(r_cube, ~r_cnt[0]);

    // Cube word of the current position
    assign byte_word = r_pos[4:2];

    // Store key parts; ignore indexes past the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_PARTS; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(KEY_PARTS))) begin
            r_key[i_cfg_idx[2:0]] <= i_cfg_data;
        end
    end

    // Advance sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_cnt       <= n_cnt;
            r_pos       <= n_pos;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_cube <= n_cube;
        r_out  <= n_out;
    end

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_fresh     = r_fresh;
        n_item      = r_item;
        n_cube      = r_cube;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        byte_mask   = 32'(r_item.data_byte) << {r_pos[1:0], 3'b000};

        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_in_data.has_byte || i_in_data.last_item)) begin
                    n_item = i_in_data;
                    if (r_fresh) begin
                        n_cube    = '0;
                        n_cube[0] = IV_WORD_0;
                        n_cube[1] = 32'(BLOCK_BYTES);
                        n_cube[2] = 32'(ROUNDS_PER_PERMUTE);
                        n_pos     = '0;
                        n_fresh   = 1'b0;
                        n_cnt     = CNT_W'(PERM_HALVES - 1);
                        n_ret     = S_KEY_A;
                        n_state   = S_PERM;
                    end else begin
                        n_state = S_ABSORB;
                    end
                end
            end
            S_PERM: begin
                n_cube = round_out;
                if (r_cnt == '0) begin
                    n_state = r_ret;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_KEY_A: begin
                for (int j = 0; j < 8; j++) begin
                    n_cube[j] = r_cube[j] ^ r_key[j / 2][32 * (j % 2) +: 32];
                end
                n_cnt   = CNT_W'(PERM_HALVES - 1);
                n_ret   = S_KEY_B;
                n_state = S_PERM;
            end
            S_KEY_B: begin
                for (int j = 0; j < 8; j++) begin
                    n_cube[j] = r_cube[j] ^ r_key[4 + j / 2][32 * (j % 2) +: 32];
                end
                n_cnt   = CNT_W'(PERM_HALVES - 1);
                n_ret   = S_ABSORB;
                n_state = S_PERM;
            end
            S_ABSORB: begin
                n_state = S_PAD;
                if (r_item.has_byte) begin
                    n_cube[{2'b00, byte_word}] = r_cube[{2'b00, byte_word}] ^ byte_mask;
                    n_pos = r_pos + 1'b1;
                    if (r_pos == 5'd31) begin
                        n_cnt   = CNT_W'(PERM_HALVES - 1);
                        n_ret   = S_PAD;
                        n_state = S_PERM;
                    end
                end
            end
            S_PAD: begin
                if (r_item.last_item) begin
                    byte_mask = 32'(PAD_BYTE) << {r_pos[1:0], 3'b000};
                    n_cube[{2'b00, byte_word}] = r_cube[{2'b00, byte_word}] ^ byte_mask;
                    n_cnt   = CNT_W'(PERM_HALVES - 1);
                    n_ret   = S_TAIL;
                    n_state = S_PERM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TAIL: begin
                n_cube[31] = r_cube[31] ^ 32'd1;
                n_cnt      = CNT_W'(FINAL_HALVES - 1);
                n_ret      = S_OUT;
                n_state    = S_PERM;
            end
            S_OUT: begin
                // Wait for the output register to drain
                if (!r_out_valid || !i_out_stall) begin
                    n_out.tag_low  = {r_cube[1], r_cube[0]};
                    n_out.tag_high = {r_cube[3], r_cube[2]};
                    n_out_valid    = 1'b1;
                    n_pos          = '0;
                    n_fresh        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A tag appears only out of the output step
    a_tag_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("tag raised outside output step");

    // A running permutation keeps going until its count is spent
    a_perm_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PERM && r_cnt != '0) |=> (r_state == S_PERM))
        else $error("permutation cut short");

    // A message start launches the rebuild and clears the start mark
    a_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_fresh && (i_in_data.has_byte || i_in_data.last_item))
        |=> (r_state == S_PERM && !r_fresh && r_ret == S_KEY_A))
        else $error("message start did not rebuild");

    // After a tag the byte position is back at zero
    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_valid || !i_out_stall)) |=> (r_pos == '0 && r_fresh))
        else $error("position not cleared after tag");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for cubehash_keyed_mac: keyed message words in, predicted tags checked.
`timescale 1ns / 1ps

module tb;
    import chmac_pkg::*;

    localparam int CLK_HALF_NS  = 10;
    localparam int RESET_CYCLES = 5;
    // Key rebuild, a block permutation and finalization all fit well inside this
    localparam int QUIET_CYCLES = 300;
    localparam int HOLD_CYCLES  = 600;
    // About 1600 words, each with its busy time plus stalls and gaps, taken several times
    localparam int TIMEOUT_NS   = 50_000_000;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 240;
    localparam int REPORT_LIMIT = 10;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0  = 'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 'd15;

    typedef enum int {KEY_ZERO, KEY_RANDOM, KEY_WALK, KEY_TOP_BIT, KEY_ONES} t_key_style;

    // Keyed CubeHash tag predictor plus the queue of tags still owed by the block
    class tag_scoreboard;
        bit [63:0] key_part [KEY_PARTS];
        bit [31:0] cube [32];
        bit [4:0]  pos;
        bit        fresh;
        t_out_item tags_due [$];
        int        errors;

        function new();
            foreach (key_part[k]) key_part[k] = '0;
            foreach (cube[i]) cube[i] = '0;
            pos    = '0;
            fresh  = 1'b1;
            errors = 0;
        endfunction

        function void set_key(logic [CFG_IDX_W-1:0] idx, bit [63:0] val);
            if (idx < KEY_PARTS) key_part[idx] = val;
        endfunction

        function bit [31:0] rotl(bit [31:0] v, int r);
            return (v << r) | (v >> (32 - r));
        endfunction

        function void mix_half(int rot, int swap_lo, int swap_hi);
            bit [31:0] t [16];
            for (int i = 0; i < 16; i++) cube[i + 16] += cube[i];
            for (int i = 0; i < 16; i++) t[i ^ swap_lo] = cube[i];
            for (int i = 0; i < 16; i++) cube[i] = rotl(t[i], rot) ^ cube[i + 16];
            for (int i = 0; i < 16; i++) t[i ^ swap_hi] = cube[i + 16];
            for (int i = 0; i < 16; i++) cube[i + 16] = t[i];
        endfunction

        function void permute();
            for (int n = 0; n < ROUNDS_PER_PERMUTE; n++) begin
                mix_half(7, 8, 2);
                mix_half(11, 4, 1);
            end
        endfunction

        // Rebuild the cube from the IV and both key halves
        function void rekey();
            foreach (cube[i]) cube[i] = '0;
            cube[0] = IV_WORD_0;
            cube[1] = BLOCK_BYTES;
            cube[2] = ROUNDS_PER_PERMUTE;
            permute();
            for (int h = 0; h < 2; h++) begin
                for (int j = 0; j < 8; j++) begin
                    cube[j] ^= (j & 1) ? key_part[h * 4 + j / 2][63:32]
                                       : key_part[h * 4 + j / 2][31:0];
                end
                permute();
            end
            pos = '0;
        endfunction

        function void mix_byte(bit [4:0] p, bit [7:0] b);
            cube[p[4:2]][p[1:0] * 8 +: 8] ^= b;
        endfunction

        // Advance the model by one accepted word and queue the tag it causes
        function void absorb_word(t_in_item w);
            t_out_item tag;
            if (!w.has_byte && !w.last_item) return;
            if (fresh) begin
                rekey();
                fresh = 1'b0;
            end
            if (w.has_byte) begin
                mix_byte(pos, w.data_byte);
                pos = pos + 1'b1;
                if (pos == 0) permute();
            end
            if (!w.last_item) return;
            mix_byte(pos, PAD_BYTE);
            permute();
            cube[31] ^= 32'd1;
            for (int n = 0; n < FINAL_PERMUTES; n++) permute();
            tag.tag_low  = {cube[1], cube[0]};
            tag.tag_high = {cube[3], cube[2]};
            tags_due.push_back(tag);
            pos   = '0;
            fresh = 1'b1;
        endfunction

        function void note_error(string what, bit [63:0] want, bit [63:0] got);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t mismatch on %s: expected %h actual %h", $realtime, what, want, got);
        endfunction

        function void check_tag(t_out_item got);
            t_out_item want;
            if (tags_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t unexpected tag %h_%h", $realtime, got.tag_high, got.tag_low);
                return;
            end
            want = tags_due.pop_front();
            if (got.tag_low != want.tag_low) note_error("tag_low", want.tag_low, got.tag_low);
            if (got.tag_high != want.tag_high) note_error("tag_high", want.tag_high, got.tag_high);
        endfunction

        function int pending();
            return tags_due.size();
        endfunction
    endclass

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    t_in_item             in_data    = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    t_out_item            out_data;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx    = '0;
    logic [63:0]          cfg_data   = '0;

    tag_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_ticket    = 0;

    cubehash_keyed_mac i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #CLK_HALF_NS i_clk = ~i_clk;

    // Check accepted tags; stall at random or hold off for a long stretch on request
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) sb.check_tag(out_data);
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic t_in_item pack_word(bit has, bit last, bit [7:0] d);
        t_in_item w;
        w.data_byte = d;
        w.has_byte  = has;
        w.last_item = last;
        return w;
    endfunction

    function automatic bit [7:0] pick_byte();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic bit [63:0] key_value(t_key_style style, int k);
        case (style)
            KEY_ZERO:    return '0;
            KEY_ONES:    return '1;
            KEY_WALK:    return 64'h1 << (k * 8 + 3);
            KEY_TOP_BIT: return {1'b1, 63'd0} | 64'(k);
            default:     return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one word after a random gap; return at the edge that accepts it
    task automatic send_word(t_in_item w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sb.absorb_word(w);
    endtask

    // Drop valid and wait until every tag is in and the block has gone quiet
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [63:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        sb.set_key(idx, val);
    endtask

    task automatic write_key(t_key_style style);
        for (int k = 0; k < KEY_PARTS; k++)
            write_reg(REG_KEY_PART_0 + CFG_IDX_W'(k), key_value(style, k));
        write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)), {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    // Whole messages of mixed lengths with idle words sprinkled in; optionally leave one open
    task automatic send_messages(int budget, bit leave_open);
        int sent;
        int len;
        int r;
        bit tail;
        sent = 0;
        while (sent < budget) begin
            r = $urandom_range(99);
            if (r < 10)      len = 0;
            else if (r < 25) len = $urandom_range(30, 34);
            else if (r < 30) len = $urandom_range(62, 66);
            else if (r < 33) len = $urandom_range(90, 100);
            else             len = $urandom_range(1, 24);
            tail = (len > 0) && $urandom_range(1);
            if ($urandom_range(9) == 0) send_word(pack_word(1'b0, 1'b0, 8'($urandom)));
            for (int i = 0; i < len - tail; i++) begin
                if ($urandom_range(99) < 8) send_word(pack_word(1'b0, 1'b0, 8'($urandom)));
                send_word(pack_word(1'b1, 1'b0, pick_byte()));
            end
            send_word(pack_word(tail, 1'b1, tail ? pick_byte() : 8'($urandom)));
            sent += len - tail + 1;
        end
        if (leave_open) begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) send_word(pack_word(1'b1, 1'b0, pick_byte()));
        end
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("cubehash_keyed_mac regression: fail");
        $finish;
    end

    initial begin
        t_key_style styles [PHASES];
        styles = '{KEY_ZERO, KEY_RANDOM, KEY_WALK, KEY_TOP_BIT, KEY_ONES, KEY_RANDOM};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle word, empty message, single-byte and multi-byte messages, byte extremes
        send_word(pack_word(1'b0, 1'b0, 8'hFF));
        send_word(pack_word(1'b0, 1'b1, 8'h00));
        send_word(pack_word(1'b1, 1'b1, 8'hFF));
        send_word(pack_word(1'b1, 1'b0, 8'h00));
        send_word(pack_word(1'b0, 1'b0, 8'h5A));
        send_word(pack_word(1'b1, 1'b0, 8'h80));
        send_word(pack_word(1'b1, 1'b0, 8'hFF));
        send_word(pack_word(1'b0, 1'b1, 8'hA5));
        send_word(pack_word(1'b1, 1'b0, 8'h01));
        send_word(pack_word(1'b1, 1'b1, 8'hFE));

        // Key change in mid-message applies only from the next message on
        send_word(pack_word(1'b1, 1'b0, 8'h7F));
        send_word(pack_word(1'b1, 1'b0, 8'hAA));
        send_word(pack_word(1'b1, 1'b0, 8'h55));
        wait_quiet();
        write_key(KEY_ONES);
        send_word(pack_word(1'b0, 1'b1, 8'h00));
        send_word(pack_word(1'b0, 1'b1, 8'hFF));

        // Writes to unmapped indexes leave the key alone
        wait_quiet();
        write_reg(REG_UNMAPPED_LO, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_UNMAPPED_HI, '1);
        cfg_we <= 1'b0;
        send_word(pack_word(1'b0, 1'b1, 8'h3C));
        send_word(pack_word(1'b1, 1'b1, 8'hC3));

        // Random phases: new key each time, rotating through the idling modes
        for (int p = 0; p < PHASES; p++) begin
            wait_quiet();
            write_key(styles[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            if (p == 1 || p == 4) hold_ticket++;
            send_messages(PHASE_WORDS, p == 1 || p == 3);
        end

        wait_quiet();
        if (sb.pending() != 0)
            $display("%0d tags never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("cubehash_keyed_mac regression: pass");
        end else begin
            $display("cubehash_keyed_mac regression: fail");
        end
        $finish;
    end

endmodule
